[design/pidpi_pkg.sv]
package pidpi_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_LOOP_MODE      = 3'd0;
	localparam logic [2:0] REG_GAIN_P         = 3'd1;
	localparam logic [2:0] REG_GAIN_I         = 3'd2;
	localparam logic [2:0] REG_GAIN_D         = 3'd3;
	localparam logic [2:0] REG_OUTPUT_LIMIT   = 3'd4;
	localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd5;

	// loop modes and item operations
	localparam logic MODE_POSITIONAL  = 1'b0;
	localparam logic MODE_INCREMENTAL = 1'b1;
	localparam logic OP_UPDATE        = 1'b0;
	localparam logic OP_CLEAR         = 1'b1;

	// working width of the summed terms, wide enough for every sum
	localparam int SUM_W = 30;
	// gain fraction bits
	localparam int FRAC_W = 8;
	localparam logic [14:0] LIMIT_RESET = 15'h7fff;

	typedef struct packed {
		logic               operation;
		logic signed [15:0] setpoint;
		logic signed [15:0] feedback;
	} pidpi_in_t;

	typedef struct packed {
		logic signed [15:0] drive;
		logic               clamped;
	} pidpi_out_t;

	typedef struct packed {
		logic               loop_mode;
		logic signed [15:0] gain_p;
		logic signed [15:0] gain_i;
		logic signed [15:0] gain_d;
		logic        [14:0] output_limit;
		logic        [14:0] integral_limit;
	} pidpi_cfg_t;

	typedef struct packed {
		logic signed [16:0] err_last;
		logic signed [16:0] err_before;
		logic signed [15:0] integral_sum;
		logic signed [15:0] drive_held;
	} pidpi_state_t;

	typedef struct packed {
		logic signed [15:0] value;
		logic               hit;
	} pidpi_clamp_t;

	// symmetric magnitude clamp
	function automatic pidpi_clamp_t clamp_abs(input logic signed [SUM_W-1:0] v,
			input logic [14:0] lim);
		logic signed [SUM_W-1:0] pos_lim;
		logic signed [SUM_W-1:0] neg_lim;
		pidpi_clamp_t            r;
		pos_lim = $signed(SUM_W'({1'b0, lim}));
		neg_lim = -pos_lim;
		if (v > pos_lim) begin
			r.value = pos_lim[15:0];
			r.hit   = 1'b1;
		end else if (v < neg_lim) begin
			r.value = neg_lim[15:0];
			r.hit   = 1'b1;
		end else begin
			r.value = v[15:0];
			r.hit   = 1'b0;
		end
		return r;
	endfunction

endpackage

[design/pidpi_core.sv]
module pidpi_core
	import pidpi_pkg::*;
(
	input  pidpi_in_t    item,
	input  pidpi_cfg_t   cfg,
	input  pidpi_state_t state,
	output pidpi_out_t   result,
	output pidpi_state_t state_next
);

	logic signed [16:0]       err;
	logic signed [18:0]       err_ext;
	logic signed [18:0]       diff1;
	logic signed [18:0]       diff2;
	logic signed [18:0]       op_p;
	logic signed [18:0]       op_d;
	logic signed [34:0]       prod_p;
	logic signed [34:0]       prod_i;
	logic signed [34:0]       prod_d;
	logic signed [SUM_W-1:0]  term_p;
	logic signed [SUM_W-1:0]  term_i;
	logic signed [SUM_W-1:0]  term_d;
	logic signed [SUM_W-1:0]  integ_raw;
	logic signed [SUM_W-1:0]  sum;
	pidpi_clamp_t             integ_c;
	pidpi_clamp_t             drive_c;

	// error and its first and second differences
	assign err     = 17'(item.setpoint) - 17'(item.feedback);
	assign err_ext = 19'(err);
	assign diff1   = err_ext - 19'(state.err_last);
	assign diff2   = err_ext - (19'(state.err_last) <<< 1) + 19'(state.err_before);

	// the three gain multipliers, operands picked by mode
	assign op_p   = (cfg.loop_mode == MODE_INCREMENTAL) ? diff1 : err_ext;
	assign op_d   = (cfg.loop_mode == MODE_INCREMENTAL) ? diff2 : diff1;
	assign prod_p = cfg.gain_p * op_p;
	assign prod_i = cfg.gain_i * err_ext;
	assign prod_d = cfg.gain_d * op_d;

	// drop the gain fraction, rounding toward minus infinity
	assign term_p = SUM_W'(prod_p >>> FRAC_W);
	assign term_i = SUM_W'(prod_i >>> FRAC_W);
	assign term_d = SUM_W'(prod_d >>> FRAC_W);

	// integral accumulation with its own clamp
	assign integ_raw = SUM_W'(state.integral_sum) + term_i;
	assign integ_c   = clamp_abs(integ_raw, cfg.integral_limit);

	// controller sum for either mode
	always_comb begin
		if (cfg.loop_mode == MODE_INCREMENTAL) begin
			sum = SUM_W'(state.drive_held) + term_p + term_i + term_d;
		end else begin
			sum = term_p + SUM_W'(integ_c.value) + term_d;
		end
	end

	assign drive_c = clamp_abs(sum, cfg.output_limit);

	// result and next history
	always_comb begin
		if (item.operation == OP_CLEAR) begin
			result     = '0;
			state_next = '0;
		end else begin
			result.drive            = drive_c.value;
			result.clamped          = drive_c.hit;
			state_next.err_last     = err;
			state_next.err_before   = state.err_last;
			state_next.integral_sum = (cfg.loop_mode == MODE_POSITIONAL) ?
				integ_c.value : state.integral_sum;
			state_next.drive_held   = drive_c.value;
		end
	end

endmodule

[design/pid_position_and_incremental_unit.sv]
// PID controller, positional or incremental, one sample per beat. An update beat
// carries setpoint and feedback and returns one clamped drive value; a clear beat
// zeroes the error history, integral and held drive and returns zero. The unit
// takes one beat per cycle unless in_stall is high: a beat is registered on entry,
// then the error, the three gain multiplies, the sums and both clamps run on it
// and land in the output register once that is free or being emptied. Controller
// state updates with the output register, keeping back-to-back beats exact. The
// user must write configuration only when idle; the unit does not enforce this.
module pid_position_and_incremental_unit
	import pidpi_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  pidpi_in_t  in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output pidpi_out_t out_data
);

	pidpi_cfg_t   cfg_q;
	pidpi_state_t state_q;
	pidpi_state_t state_next;
	pidpi_in_t    item_s1;
	logic         valid_s1;
	pidpi_out_t   result;
	pidpi_out_t   out_data_q;
	logic         out_valid_q;
	logic         advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.loop_mode      <= MODE_POSITIONAL;
			cfg_q.gain_p         <= '0;
			cfg_q.gain_i         <= '0;
			cfg_q.gain_d         <= '0;
			cfg_q.output_limit   <= LIMIT_RESET;
			cfg_q.integral_limit <= LIMIT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_LOOP_MODE:      cfg_q.loop_mode      <= cfg_data[0];
				REG_GAIN_P:         cfg_q.gain_p         <= cfg_data;
				REG_GAIN_I:         cfg_q.gain_i         <= cfg_data;
				REG_GAIN_D:         cfg_q.gain_d         <= cfg_data;
				REG_OUTPUT_LIMIT:   cfg_q.output_limit   <= cfg_data[14:0];
				REG_INTEGRAL_LIMIT: cfg_q.integral_limit <= cfg_data[14:0];
				default: begin
				end
			endcase
		end
	end

	// the input stage moves on when the output register is free or being emptied
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	pidpi_core u_core (
		.item       (item_s1),
		.cfg        (cfg_q),
		.state      (state_q),
		.result     (result),
		.state_next (state_next)
	);

	// controller history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

[design/pidpi_checker.sv]
module pidpi_checker
	import pidpi_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input pidpi_out_t out_data
);

	// a stalled result beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	// limits never exceed 32767, so the most negative code cannot appear
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.drive != 16'sh8000)
		else $error("drive outside the limit range");

	// with the output empty there is no back pressure on the input
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with output register empty");

	// a beat taken while the output is empty shows up after the input and output registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |-> ##2 out_valid)
		else $error("result missing after accepted beat");

endmodule

bind pid_position_and_incremental_unit pidpi_checker u_checker (.*);

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top
	import pidpi_pkg::*;
();

	localparam int          HALF_PERIOD   = 4;
	localparam int          RESET_CYCLES  = 7;
	localparam int          HOLD_CYCLES   = 300;
	localparam int          WATCHDOG_MAX  = 4000;
	localparam int          DRAIN_CYCLES  = 6;
	localparam int          RANDOM_PHASES = 8;
	localparam int          PHASE_ITEMS   = 205;
	// indexes past the register list, writes there must be ignored
	localparam logic [2:0]  REG_SPARE_LO  = 3'd6;
	localparam logic [2:0]  REG_SPARE_HI  = 3'd7;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_write = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	pidpi_in_t   in_data   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	pidpi_out_t  out_data;

	pid_position_and_incremental_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// controller copy: settings and loop history
	pidpi_cfg_t         setting;
	logic signed [16:0] err_prev;
	logic signed [16:0] err_prev2;
	logic signed [15:0] integ_acc;
	logic signed [15:0] drive_hold;

	pidpi_in_t  beats_to_send[$];
	pidpi_out_t drive_expected[$];
	pidpi_out_t want;

	int  send_idle_pct  = 0;
	int  recv_stall_pct = 0;
	bit  hold_req       = 1'b0;
	bit  hold_done      = 1'b0;
	int  hold_cnt       = 0;
	int  beats_queued   = 0;
	int  results_seen   = 0;
	int  fail_count     = 0;
	int  n_clear        = 0;
	int  n_update       = 0;
	int  n_incremental  = 0;
	int  n_clamped      = 0;
	int  n_settings     = 0;
	int  quiet_cycles   = 0;

	always #HALF_PERIOD clk = ~clk;

	// symmetric magnitude limit
	function automatic longint limit_mag(input longint v, input longint lim, output bit hit);
		hit = 1'b0;
		if (v > lim) begin
			hit = 1'b1;
			return lim;
		end
		if (v < -lim) begin
			hit = 1'b1;
			return -lim;
		end
		return v;
	endfunction

	// one controller step, returns the expected drive beat
	function automatic pidpi_out_t predict_step(input pidpi_in_t beat);
		longint     err;
		longint     last;
		longint     older;
		longint     kp;
		longint     ki;
		longint     kd;
		longint     sum;
		longint     integ;
		bit         ihit;
		bit         ohit;
		pidpi_out_t res;
		res = '0;
		if (beat.operation == OP_CLEAR) begin
			err_prev   = '0;
			err_prev2  = '0;
			integ_acc  = '0;
			drive_hold = '0;
			n_clear++;
			return res;
		end
		n_update++;
		err   = longint'($signed(beat.setpoint)) - longint'($signed(beat.feedback));
		last  = longint'(err_prev);
		older = longint'(err_prev2);
		kp    = longint'($signed(setting.gain_p));
		ki    = longint'($signed(setting.gain_i));
		kd    = longint'($signed(setting.gain_d));
		if (setting.loop_mode == MODE_POSITIONAL) begin
			integ = limit_mag(longint'(integ_acc) + ((ki * err) >>> FRAC_W),
				longint'(setting.integral_limit), ihit);
			integ_acc = integ[15:0];
			sum = ((kp * err) >>> FRAC_W) + integ + ((kd * (err - last)) >>> FRAC_W);
		end else begin
			n_incremental++;
			sum = longint'(drive_hold)
				+ ((kp * (err - last)) >>> FRAC_W)
				+ ((ki * err) >>> FRAC_W)
				+ ((kd * (err - 2 * last + older)) >>> FRAC_W);
		end
		sum         = limit_mag(sum, longint'(setting.output_limit), ohit);
		drive_hold  = sum[15:0];
		err_prev2   = err_prev;
		err_prev    = err[16:0];
		res.drive   = sum[15:0];
		res.clamped = ohit;
		return res;
	endfunction

	// driver: offers queued beats, predicts on each accepted one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else begin
			if (in_valid && !in_stall)
				drive_expected.push_back(predict_step(in_data));
			if (!in_valid || !in_stall) begin
				if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data  <= beats_to_send.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: random stall, one long hold-off on request, field compare
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (drive_expected.size() == 0) begin
					$error("unexpected result beat: drive %0d clamped %0b",
						out_data.drive, out_data.clamped);
					fail_count++;
				end else begin
					want = drive_expected.pop_front();
					if (out_data.drive !== want.drive) begin
						$error("drive mismatch: expected %0d, got %0d",
							want.drive, out_data.drive);
						fail_count++;
					end
					if (out_data.clamped !== want.clamped) begin
						$error("clamped mismatch: expected %0b, got %0b",
							want.clamped, out_data.clamped);
						fail_count++;
					end
					if (want.clamped)
						n_clamped++;
					results_seen++;
				end
			end
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				hold_cnt++;
				if (hold_cnt >= HOLD_CYCLES)
					hold_done = 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// watchdog on cycles with no beat moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_MAX) begin
				$display("timeout: no beat moved for %0d cycles", WATCHDOG_MAX);
				$display("** pid_position_and_incremental_unit: FAILED **");
				$finish;
			end
		end
	end

	task automatic push_beat(input logic op, input int sp, input int fb);
		pidpi_in_t b;
		b.operation = op;
		b.setpoint  = 16'(sp);
		b.feedback  = 16'(fb);
		beats_to_send.push_back(b);
		beats_queued++;
	endtask

	// wait until every queued beat has come back, then let the pipe empty
	task automatic settle();
		while (results_seen < beats_queued)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
		REG_LOOP_MODE:      setting.loop_mode      = val[0];
		REG_GAIN_P:         setting.gain_p         = val;
		REG_GAIN_I:         setting.gain_i         = val;
		REG_GAIN_D:         setting.gain_d         = val;
		REG_OUTPUT_LIMIT:   setting.output_limit   = val[14:0];
		REG_INTEGRAL_LIMIT: setting.integral_limit = val[14:0];
		default: ;
		endcase
	endtask

	// full register set, plus writes to the spare indexes
	task automatic load_settings(input logic mode, input logic [15:0] kp,
			input logic [15:0] ki, input logic [15:0] kd, input logic [14:0] olim,
			input logic [14:0] ilim);
		write_reg(REG_SPARE_LO, 16'($urandom));
		write_reg(REG_LOOP_MODE, {15'($urandom), mode});
		write_reg(REG_GAIN_P, kp);
		write_reg(REG_GAIN_I, ki);
		write_reg(REG_GAIN_D, kd);
		write_reg(REG_OUTPUT_LIMIT, {1'($urandom), olim});
		write_reg(REG_INTEGRAL_LIMIT, {1'($urandom), ilim});
		write_reg(REG_SPARE_HI, 16'($urandom));
		cfg_write <= 1'b0;
		@(posedge clk);
		n_settings++;
	endtask

	initial begin
		logic [15:0] kp;
		logic [15:0] ki;
		logic [15:0] kd;
		logic [14:0] olim;
		logic [14:0] ilim;
		int          r;
		int          sp;
		int          delta;

		setting.loop_mode      = MODE_POSITIONAL;
		setting.gain_p         = '0;
		setting.gain_i         = '0;
		setting.gain_d         = '0;
		setting.output_limit   = LIMIT_RESET;
		setting.integral_limit = LIMIT_RESET;
		err_prev   = '0;
		err_prev2  = '0;
		integ_acc  = '0;
		drive_hold = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: all gains zero
		push_beat(OP_UPDATE, 1000, -1000);
		push_beat(OP_UPDATE, 32767, -32768);
		settle();

		// positional, unit gain, widest error both ways, then clear
		load_settings(MODE_POSITIONAL, 16'h0100, 16'h0040, 16'h0080, 15'h7fff, 15'h7fff);
		push_beat(OP_UPDATE, 32767, -32768);
		push_beat(OP_UPDATE, -32768, 32767);
		push_beat(OP_UPDATE, 0, 0);
		push_beat(OP_UPDATE, 100, -50);
		push_beat(OP_UPDATE, -200, 300);
		push_beat(OP_CLEAR, 32767, -32768);
		settle();

		// extreme gains with tight limits, integral saturates
		load_settings(MODE_POSITIONAL, 16'h8000, 16'h7fff, 16'h7fff, 15'd1000, 15'd500);
		push_beat(OP_UPDATE, 5, 0);
		push_beat(OP_UPDATE, -7, 3);
		push_beat(OP_UPDATE, 32767, -32768);
		push_beat(OP_UPDATE, -32768, 32767);
		push_beat(OP_UPDATE, 12, 12);
		settle();

		// zero limits pin everything at zero
		load_settings(MODE_POSITIONAL, 16'h0200, 16'h0100, 16'h0100, 15'd0, 15'd0);
		push_beat(OP_UPDATE, 300, 0);
		push_beat(OP_UPDATE, -300, 0);
		push_beat(OP_UPDATE, 0, 0);
		settle();

		// switch to incremental with history carried over, then clear
		load_settings(MODE_INCREMENTAL, 16'h0100, 16'h0080, 16'h0040, 15'h7fff, 15'h7fff);
		push_beat(OP_UPDATE, 50, 10);
		push_beat(OP_UPDATE, -40, 20);
		push_beat(OP_UPDATE, 32767, -32768);
		push_beat(OP_UPDATE, 32767, -32768);
		push_beat(OP_UPDATE, -32768, 32767);
		push_beat(OP_CLEAR, 0, 0);
		push_beat(OP_UPDATE, 1, 0);
		settle();

		// incremental with extreme gains and a zero output limit
		load_settings(MODE_INCREMENTAL, 16'h7fff, 16'h8000, 16'h8000, 15'd0, 15'd9);
		push_beat(OP_UPDATE, 3, 1);
		push_beat(OP_UPDATE, -2, 5);
		settle();

		// random phases, settings and idling patterns rotate
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
			default: begin send_idle_pct = 7; recv_stall_pct = 7; end
			endcase
			if (ph % 3 == 0) begin
				kp = 16'($urandom);
				ki = 16'($urandom);
				kd = 16'($urandom);
			end else begin
				kp = 16'($urandom_range(2048) - 1024);
				ki = 16'($urandom_range(512) - 256);
				kd = 16'($urandom_range(1024) - 512);
			end
			if (ph == 2) begin
				olim = 15'h7fff;
				ilim = 15'h7fff;
			end else if (ph == 5) begin
				olim = 15'd0;
				ilim = 15'($urandom);
			end else begin
				olim = 15'($urandom_range(32767, 200));
				ilim = 15'($urandom_range(32767, 100));
			end
			load_settings(1'(ph), kp, ki, kd, olim, ilim);
			// long output hold-off while the sender keeps going
			if (ph == 4)
				hold_req = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(99);
				if (r < 4) begin
					push_beat(OP_CLEAR, int'($urandom), int'($urandom));
				end else if (r < 65) begin
					// tracking loop: feedback close to setpoint
					sp    = int'($urandom_range(16000)) - 8000;
					delta = int'($urandom_range(400)) - 200;
					push_beat(OP_UPDATE, sp, sp - delta);
				end else begin
					push_beat(OP_UPDATE, int'($urandom), int'($urandom));
				end
			end
			settle();
		end

		if (drive_expected.size() != 0) begin
			$error("%0d expected results never arrived", drive_expected.size());
			fail_count++;
		end
		$display("covered %0d updates (%0d incremental) and %0d clears over %0d settings",
			n_update, n_incremental, n_clear, n_settings);
		$display("%0d results checked, %0d clamped, %0d mismatches",
			results_seen, n_clamped, fail_count);
		if (fail_count == 0)
			$display("** pid_position_and_incremental_unit: PASSED **");
		else
			$display("** pid_position_and_incremental_unit: FAILED **");
		$finish;
	end

endmodule
